/* rtl/vfcm_pkg.sv */
// Shared types, constants and helper functions for the voxel face culling mesher.
// Has no dependencies; every other file of the block imports it.
package vfcm_pkg;

    // Fixed field widths of the item and result ports.
    localparam int COORD_W   = 4;
    localparam int IDX_W     = 13;
    localparam int DIR_W     = 3;
    localparam int NUM_DIRS  = 6;

    // Depth of the command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Opcodes of an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Face directions, in the order they are tested.
    localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd0;
    localparam logic [DIR_W-1:0] DIR_POS_X = 3'd1;
    localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd2;
    localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd3;
    localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd4;
    localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd5;

    // Rows of the store read for a query, in issue order.
    localparam logic [2:0] ROW_CENTER = 3'd0;
    localparam logic [2:0] ROW_NEG_X  = 3'd1;
    localparam logic [2:0] ROW_POS_X  = 3'd2;
    localparam logic [2:0] ROW_NEG_Y  = 3'd3;
    localparam logic [2:0] ROW_POS_Y  = 3'd4;
    localparam logic [2:0] ROW_COUNT  = 3'd5;

    // One classified command as it travels through the queue.
    typedef struct packed {
        logic                is_query;
        logic                in_cube;
        logic                solid;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COORD_W-1:0]  z;
        logic [NUM_DIRS-1:0] nbr_in;
        logic [IDX_W-1:0]    base;
    } cmd_t;

    // Corner offsets {dx,dy,dz} of vertices v1..v4 of a face, v1 in the top bits.
    function automatic logic [11:0] corner_offsets(input logic [DIR_W-1:0] dir);
        logic [11:0] offs;
        unique case (dir)
            DIR_NEG_X: offs = 12'b000_001_010_011;
            DIR_POS_X: offs = 12'b100_110_101_111;
            DIR_NEG_Y: offs = 12'b000_100_001_101;
            DIR_POS_Y: offs = 12'b010_011_110_111;
            DIR_NEG_Z: offs = 12'b000_010_100_110;
            DIR_POS_Z: offs = 12'b001_101_011_111;
            default:   offs = 12'b000_000_000_000;
        endcase
        return offs;
    endfunction

endpackage

/* rtl/vfcm_front.sv */
// Front part: classifies an incoming item into a queue command.
// Depends on vfcm_pkg.
module vfcm_front #(
    parameter int CHUNK_EDGE = 16
) (
    input  logic                         opcode,
    input  logic [vfcm_pkg::COORD_W-1:0] pos_x,
    input  logic [vfcm_pkg::COORD_W-1:0] pos_y,
    input  logic [vfcm_pkg::COORD_W-1:0] pos_z,
    input  logic                         solid,
    output vfcm_pkg::cmd_t               cmd
);
    import vfcm_pkg::*;

    localparam int VSIDE = CHUNK_EDGE + 1;
    localparam logic [IDX_W-1:0] V_IDX  = IDX_W'(VSIDE);
    localparam logic [IDX_W-1:0] VV_IDX = IDX_W'(VSIDE * VSIDE);

    // Range checks, neighbor presence and the base vertex index of the voxel.
    always_comb
    begin
        cmd.is_query = (opcode == OP_QUERY);
        cmd.in_cube  = (int'(pos_x) < CHUNK_EDGE) && (int'(pos_y) < CHUNK_EDGE)
                       && (int'(pos_z) < CHUNK_EDGE);
        cmd.solid    = solid;
        cmd.x        = pos_x;
        cmd.y        = pos_y;
        cmd.z        = pos_z;

        cmd.nbr_in            = '0;
        cmd.nbr_in[DIR_NEG_X] = (pos_x != '0);
        cmd.nbr_in[DIR_POS_X] = (int'(pos_x) + 1 < CHUNK_EDGE);
        cmd.nbr_in[DIR_NEG_Y] = (pos_y != '0);
        cmd.nbr_in[DIR_POS_Y] = (int'(pos_y) + 1 < CHUNK_EDGE);
        cmd.nbr_in[DIR_NEG_Z] = (pos_z != '0);
        cmd.nbr_in[DIR_POS_Z] = (int'(pos_z) + 1 < CHUNK_EDGE);

        // The largest index fits in 13 bits, so 13-bit arithmetic is exact.
        cmd.base = IDX_W'(pos_x) * VV_IDX + IDX_W'(pos_y) * V_IDX + IDX_W'(pos_z);
    end

endmodule

/* rtl/vfcm_cmd_fifo.sv */
// Short command queue that decouples the front part from the back part.
// Depends on vfcm_pkg.
module vfcm_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vfcm_pkg::cmd_t wr_cmd,
    input  logic           pop,
    output vfcm_pkg::cmd_t rd_cmd,
    output logic           full,
    output logic           empty
);
    import vfcm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    count_reg, count_next;

    assign full   = (count_reg == DEPTH_CNT);
    assign empty  = (count_reg == '0);
    assign rd_cmd = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    // The queue is never read empty nor written full.
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("command queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("command queue pushed while full");
    // A lone transfer into the queue leaves it holding at least one command.
    assert property (@(posedge clk) disable iff (!rst_n) (push && !pop) |=> !empty)
        else $error("command queue lost a pushed command");

endmodule

/* rtl/vfcm_back.sv */
// Back part: owns the occupancy store, carries out writes and queries, emits faces.
// Depends on vfcm_pkg.
module vfcm_back #(
    parameter int CHUNK_EDGE = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vfcm_pkg::cmd_t               cmd,
    input  logic                         cmd_empty,
    output logic                         cmd_pop,
    output logic                         clearing,
    output logic                         strobe,
    output logic                         face_valid,
    output logic [vfcm_pkg::DIR_W-1:0]   face_dir,
    output logic [vfcm_pkg::IDX_W-1:0]   index_a,
    output logic [vfcm_pkg::IDX_W-1:0]   index_b,
    output logic [vfcm_pkg::IDX_W-1:0]   index_c,
    output logic [vfcm_pkg::IDX_W-1:0]   index_d,
    output logic [vfcm_pkg::IDX_W-1:0]   index_e,
    output logic [vfcm_pkg::IDX_W-1:0]   index_f,
    output logic                         last
);
    import vfcm_pkg::*;

    // Store is organized as one row of CHUNK_EDGE bits (along z) per (x,y).
    localparam int ROWS  = CHUNK_EDGE * CHUNK_EDGE;
    localparam int AW    = $clog2(ROWS);
    localparam int CW    = $clog2(CHUNK_EDGE);
    localparam int VSIDE = CHUNK_EDGE + 1;
    localparam logic [AW-1:0]    LAST_ROW = AW'(ROWS - 1);
    localparam logic [AW-1:0]    EDGE_A   = AW'(CHUNK_EDGE);
    localparam logic [IDX_W-1:0] V_IDX    = IDX_W'(VSIDE);
    localparam logic [IDX_W-1:0] VV_IDX   = IDX_W'(VSIDE * VSIDE);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_WREAD = 6'b000100,
        ST_WRITE = 6'b001000,
        ST_READ  = 6'b010000,
        ST_EMIT  = 6'b100000
    } back_state_t;

    function automatic logic [AW-1:0] row_addr(input logic [COORD_W:0] cx,
                                               input logic [COORD_W:0] cy);
        return AW'(cx) * EDGE_A + AW'(cy);
    endfunction

    function automatic logic [IDX_W-1:0] vertex(input logic [IDX_W-1:0] base,
                                                input logic [2:0]       off);
        return base + (off[2] ? VV_IDX : '0) + (off[1] ? V_IDX : '0) + IDX_W'(off[0]);
    endfunction

    back_state_t          state_reg, state_next;
    cmd_t                 cur_reg, cur_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [2:0]           rd_cnt_reg, rd_cnt_next;
    logic [NUM_DIRS-1:0]  mask_reg, mask_next;
    logic                 center_reg, center_next;
    logic [NUM_DIRS-1:0]  nbr_reg, nbr_next;
    logic                 strobe_reg, strobe_next;
    logic                 face_valid_reg, face_valid_next;
    logic [DIR_W-1:0]     face_dir_reg, face_dir_next;
    logic [IDX_W-1:0]     vert_reg [4];
    logic [IDX_W-1:0]     vert_next [4];
    logic                 last_reg, last_next;

    logic [CHUNK_EDGE-1:0] mem [ROWS];
    logic [CHUNK_EDGE-1:0] rdata_reg;
    logic [AW-1:0]         raddr;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [CHUNK_EDGE-1:0] wdata;

    logic [COORD_W:0]      x5, y5, xm, xp, ym, yp;
    logic [AW-1:0]         center_addr;
    logic [CW-1:0]         z_idx, zm_idx, zp_idx;
    logic [2:0]            cap_row;
    logic [DIR_W-1:0]      sel_dir;
    logic [NUM_DIRS-1:0]   remaining;
    logic [11:0]           offs;

    // Neighbor coordinates and bit positions of the current command.
    always_comb
    begin
        x5          = {1'b0, cur_reg.x};
        y5          = {1'b0, cur_reg.y};
        xm          = x5 - (COORD_W + 1)'(1);
        xp          = x5 + (COORD_W + 1)'(1);
        ym          = y5 - (COORD_W + 1)'(1);
        yp          = y5 + (COORD_W + 1)'(1);
        center_addr = row_addr(x5, y5);
        z_idx       = CW'(cur_reg.z);
        zm_idx      = cur_reg.nbr_in[DIR_NEG_Z] ? z_idx - CW'(1) : z_idx;
        zp_idx      = cur_reg.nbr_in[DIR_POS_Z] ? z_idx + CW'(1) : z_idx;
        cap_row     = rd_cnt_reg - 3'd1;
    end

    // Lowest pending face direction and its corner offsets.
    always_comb
    begin
        sel_dir = DIR_NEG_X;
        for (int i = NUM_DIRS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel_dir = DIR_W'(i);
            end
        end
        remaining          = mask_reg;
        remaining[sel_dir] = 1'b0;
        offs               = corner_offsets(sel_dir);
    end

    // Read address: one row per cycle for a query, the center row for a write.
    always_comb
    begin
        raddr = '0;
        if (state_reg == ST_WREAD)
        begin
            raddr = center_addr;
        end
        else if (state_reg == ST_READ)
        begin
            case (rd_cnt_reg)
                ROW_NEG_X: raddr = cur_reg.nbr_in[DIR_NEG_X] ? row_addr(xm, y5) : center_addr;
                ROW_POS_X: raddr = cur_reg.nbr_in[DIR_POS_X] ? row_addr(xp, y5) : center_addr;
                ROW_NEG_Y: raddr = cur_reg.nbr_in[DIR_NEG_Y] ? row_addr(x5, ym) : center_addr;
                ROW_POS_Y: raddr = cur_reg.nbr_in[DIR_POS_Y] ? row_addr(x5, yp) : center_addr;
                default:   raddr = center_addr;
            endcase
        end
    end

    // Sequencer of the back part.
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        clr_cnt_next    = clr_cnt_reg;
        rd_cnt_next     = rd_cnt_reg;
        mask_next       = mask_reg;
        center_next     = center_reg;
        nbr_next        = nbr_reg;
        strobe_next     = 1'b0;
        face_valid_next = face_valid_reg;
        face_dir_next   = face_dir_reg;
        vert_next       = vert_reg;
        last_next       = last_reg;
        cmd_pop         = 1'b0;
        we              = 1'b0;
        waddr           = center_addr;
        wdata           = rdata_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                we           = 1'b1;
                waddr        = clr_cnt_reg;
                wdata        = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop     = 1'b1;
                    cur_next    = cmd;
                    rd_cnt_next = '0;
                    if (!cmd.is_query)
                    begin
                        state_next = cmd.in_cube ? ST_WREAD : ST_IDLE;
                    end
                    else if (cmd.in_cube)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        // A voxel outside the cube is empty: no faces.
                        mask_next  = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_WREAD:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Read-modify-write of the center row.
                we           = 1'b1;
                wdata        = rdata_reg;
                wdata[z_idx] = cur_reg.solid;
                state_next   = ST_IDLE;
            end
            ST_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 3'd1;
                if (rd_cnt_reg != '0)
                begin
                    case (cap_row)
                        ROW_CENTER:
                        begin
                            center_next         = rdata_reg[z_idx];
                            nbr_next[DIR_NEG_Z] = cur_reg.nbr_in[DIR_NEG_Z] & rdata_reg[zm_idx];
                            nbr_next[DIR_POS_Z] = cur_reg.nbr_in[DIR_POS_Z] & rdata_reg[zp_idx];
                        end
                        ROW_NEG_X: nbr_next[DIR_NEG_X] = cur_reg.nbr_in[DIR_NEG_X] & rdata_reg[z_idx];
                        ROW_POS_X: nbr_next[DIR_POS_X] = cur_reg.nbr_in[DIR_POS_X] & rdata_reg[z_idx];
                        ROW_NEG_Y: nbr_next[DIR_NEG_Y] = cur_reg.nbr_in[DIR_NEG_Y] & rdata_reg[z_idx];
                        ROW_POS_Y: nbr_next[DIR_POS_Y] = cur_reg.nbr_in[DIR_POS_Y] & rdata_reg[z_idx];
                        default:   nbr_next = nbr_reg;
                    endcase
                end
                if (rd_cnt_reg == ROW_COUNT)
                begin
                    mask_next  = center_reg ? ~nbr_next : '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                if (mask_reg == '0)
                begin
                    // Empty or fully enclosed voxel: one result marked not valid.
                    face_valid_next = 1'b0;
                    face_dir_next   = '0;
                    for (int k = 0; k < 4; k++)
                    begin
                        vert_next[k] = '0;
                    end
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    face_valid_next = 1'b1;
                    face_dir_next   = sel_dir;
                    for (int k = 0; k < 4; k++)
                    begin
                        vert_next[k] = vertex(cur_reg.base, offs[(3 - k) * 3 +: 3]);
                    end
                    last_next = (remaining == '0);
                    mask_next = remaining;
                    if (remaining == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            rd_cnt_reg  <= '0;
            mask_reg    <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            mask_reg    <= mask_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        center_reg     <= center_next;
        nbr_reg        <= nbr_next;
        face_valid_reg <= face_valid_next;
        face_dir_reg   <= face_dir_next;
        vert_reg       <= vert_next;
        last_reg       <= last_next;
    end

    // Occupancy store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign clearing   = (state_reg == ST_CLEAR);
    assign strobe     = strobe_reg;
    assign face_valid = face_valid_reg;
    assign face_dir   = face_dir_reg;
    assign index_a    = vert_reg[0];
    assign index_b    = vert_reg[1];
    assign index_c    = vert_reg[2];
    assign index_d    = vert_reg[1];
    assign index_e    = vert_reg[3];
    assign index_f    = vert_reg[2];
    assign last       = last_reg;

    // A result only follows a cycle of the emit state.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(state_reg == ST_EMIT))
        else $error("result transfer outside the emit state");
    // A result marked not valid always closes its query.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && !face_valid_reg) |-> last_reg)
        else $error("invalid result not marked last");
    // Pending faces in the emit state give a valid face in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && mask_reg != '0) |=> (strobe_reg && face_valid_reg))
        else $error("pending face not emitted");

endmodule

/* rtl/voxel_face_culling_mesher_top.sv */
// Once a query's results begin, they are driven one per cycle.
// The back part reads then rewrites the center row for a write, and reads rows then emits for a query.
// Query rate is set by the single read port of the store, which reads five rows in turn.
// Reset clears the store row by row with busy held high.
// Results go out on a one-cycle strobe; the receiver cannot stall them.
// Top level: front classifier, command queue and back part. Depends on vfcm_pkg.
module voxel_face_culling_mesher_top #(
    parameter int CHUNK_EDGE = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         opcode,
    input  logic [vfcm_pkg::COORD_W-1:0] pos_x,
    input  logic [vfcm_pkg::COORD_W-1:0] pos_y,
    input  logic [vfcm_pkg::COORD_W-1:0] pos_z,
    input  logic                         solid,
    output logic                         strobe,
    output logic                         face_valid,
    output logic [vfcm_pkg::DIR_W-1:0]   face_dir,
    output logic [vfcm_pkg::IDX_W-1:0]   index_a,
    output logic [vfcm_pkg::IDX_W-1:0]   index_b,
    output logic [vfcm_pkg::IDX_W-1:0]   index_c,
    output logic [vfcm_pkg::IDX_W-1:0]   index_d,
    output logic [vfcm_pkg::IDX_W-1:0]   index_e,
    output logic [vfcm_pkg::IDX_W-1:0]   index_f,
    output logic                         last
);
    import vfcm_pkg::*;

    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;
    logic clearing;

    // An item transfers when the queue has room and the store is not being cleared.
    assign busy = full | clearing;
    assign push = start & ~busy;

    vfcm_front #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_front (
        .opcode (opcode),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .solid  (solid),
        .cmd    (front_cmd)
    );

    vfcm_cmd_fifo u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (pop),
        .rd_cmd (queue_cmd),
        .full   (full),
        .empty  (empty)
    );

    vfcm_back #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (queue_cmd),
        .cmd_empty  (empty),
        .cmd_pop    (pop),
        .clearing   (clearing),
        .strobe     (strobe),
        .face_valid (face_valid),
        .face_dir   (face_dir),
        .index_a    (index_a),
        .index_b    (index_b),
        .index_c    (index_c),
        .index_d    (index_d),
        .index_e    (index_e),
        .index_f    (index_f),
        .last       (last)
    );

endmodule

/* tb/voxel_face_culling_mesher_top_tb.sv */
// Self-checking testbench for the voxel face culling mesher: writes and queries are driven
// with random gaps and every face result is checked against an in-bench occupancy predictor.
// Depends on vfcm_pkg and voxel_face_culling_mesher_top.
`timescale 1ns / 1ps

module voxel_face_culling_mesher_top_tb;
    import vfcm_pkg::*;

    localparam int EDGE          = 16;
    localparam int VSIDE         = EDGE + 1;
    localparam int RANDOM_ITEMS  = 260;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_CAP    = 40;

    // One face result as seen on the output ports; index[0] is index_a.
    typedef struct packed {
        logic                  face_valid;
        logic [DIR_W-1:0]      face_dir;
        logic [5:0][IDX_W-1:0] index;
        logic                  last;
    } face_result_t;

    // Occupancy predictor and the queue of faces it expects from the block.
    class voxel_face_board;
        bit           occupancy [EDGE*EDGE*EDGE];
        face_result_t expected_faces [$];
        int           errors;
        int           reports;
        int           writes;
        int           queries;
        int           faces;
        int           bare_results;

        function new();
            errors       = 0;
            reports      = 0;
            writes       = 0;
            queries      = 0;
            faces        = 0;
            bare_results = 0;
            foreach (occupancy[i])
                occupancy[i] = 1'b0;
        endfunction

        // Voxels outside the cube read as empty.
        function bit occupied(int x, int y, int z);
            if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE)
                return 1'b0;
            return occupancy[(x * EDGE + y) * EDGE + z];
        endfunction

        function logic [IDX_W-1:0] vertex_index(int x, int y, int z);
            return IDX_W'(x * VSIDE * VSIDE + y * VSIDE + z);
        endfunction

        function int pending();
            return expected_faces.size();
        endfunction

        // Adds one result at the tail of the expected queue.
        function void append_face(face_result_t r);
            expected_faces.insert(expected_faces.size(), r);
        endfunction

        // Applies one accepted transfer and queues the faces a query should produce.
        function void note_command(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                   logic [COORD_W-1:0] z, logic s);
            int               c [3];
            int               n [3];
            int               corner [4][3];
            logic [IDX_W-1:0] v [4];
            int               axis;
            int               u;
            int               w;
            bit               neg;
            int               found;
            int               d;
            int               k;
            face_result_t     r;
            c[0] = int'(x);
            c[1] = int'(y);
            c[2] = int'(z);
            if (op == OP_WRITE) begin
                if (c[0] < EDGE && c[1] < EDGE && c[2] < EDGE)
                    occupancy[(c[0] * EDGE + c[1]) * EDGE + c[2]] = s;
                writes++;
                return;
            end
            queries++;
            found = 0;
            if (occupied(c[0], c[1], c[2])) begin
                for (d = 0; d < NUM_DIRS; d++) begin
                    axis = d / 2;
                    neg  = (d % 2 == 0);
                    n    = c;
                    n[axis] += neg ? -1 : 1;
                    if (occupied(n[0], n[1], n[2]))
                        continue;
                    // The face lies on the near or far plane of the voxel along its axis;
                    // v2 and v3 step along the two other axes, swapped on positive faces.
                    u = (axis + 2) % 3;
                    w = (axis + 1) % 3;
                    for (k = 0; k < 4; k++) begin
                        corner[k] = c;
                        if (!neg)
                            corner[k][axis] += 1;
                    end
                    corner[1][neg ? u : w] += 1;
                    corner[2][neg ? w : u] += 1;
                    corner[3][u] += 1;
                    corner[3][w] += 1;
                    for (k = 0; k < 4; k++)
                        v[k] = vertex_index(corner[k][0], corner[k][1], corner[k][2]);
                    r.face_valid = 1'b1;
                    r.face_dir   = DIR_W'(d);
                    r.index[0]   = v[0];
                    r.index[1]   = v[1];
                    r.index[2]   = v[2];
                    r.index[3]   = v[1];
                    r.index[4]   = v[3];
                    r.index[5]   = v[2];
                    r.last       = 1'b0;
                    append_face(r);
                    found++;
                end
            end
            if (found == 0) begin
                // Empty or fully enclosed voxel: a single result marked not valid.
                r      = '0;
                r.last = 1'b1;
                append_face(r);
                bare_results++;
            end else begin
                expected_faces[expected_faces.size() - 1].last = 1'b1;
                faces += found;
            end
        endfunction

        function void report(string field, int want_v, int got_v);
            errors++;
            if (reports < REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
                         want_v, got_v);
            reports++;
        endfunction

        // Compares one result transfer with the oldest expected face.
        function void check_face(face_result_t got);
            face_result_t want;
            string        index_names [6];
            int           k;
            index_names = '{"index_a", "index_b", "index_c", "index_d", "index_e", "index_f"};
            if (expected_faces.size() == 0) begin
                errors++;
                if (reports < REPORT_CAP)
                    $display("%0t: unexpected result, expected none, actual dir %0d valid %0d",
                             $time, got.face_dir, got.face_valid);
                reports++;
                return;
            end
            want = expected_faces.pop_front();
            if (got.face_valid !== want.face_valid)
                report("face_valid", int'(want.face_valid), int'(got.face_valid));
            if (got.face_dir !== want.face_dir)
                report("face_dir", int'(want.face_dir), int'(got.face_dir));
            for (k = 0; k < 6; k++)
                if (got.index[k] !== want.index[k])
                    report(index_names[k], int'(want.index[k]), int'(got.index[k]));
            if (got.last !== want.last)
                report("last", int'(want.last), int'(got.last));
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 opcode;
    logic [COORD_W-1:0]   pos_x;
    logic [COORD_W-1:0]   pos_y;
    logic [COORD_W-1:0]   pos_z;
    logic                 solid;
    logic                 strobe;
    logic                 face_valid;
    logic [DIR_W-1:0]     face_dir;
    logic [IDX_W-1:0]     index_a;
    logic [IDX_W-1:0]     index_b;
    logic [IDX_W-1:0]     index_c;
    logic [IDX_W-1:0]     index_d;
    logic [IDX_W-1:0]     index_e;
    logic [IDX_W-1:0]     index_f;
    logic                 last;

    voxel_face_board board;
    bit              no_gaps;
    int              idle_cycles;

    voxel_face_culling_mesher_top #(
        .CHUNK_EDGE (EDGE)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .solid      (solid),
        .strobe     (strobe),
        .face_valid (face_valid),
        .face_dir   (face_dir),
        .index_a    (index_a),
        .index_b    (index_b),
        .index_c    (index_c),
        .index_d    (index_d),
        .index_e    (index_e),
        .index_f    (index_f),
        .last       (last)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Result monitor: each strobe is one transfer that cannot be held off.
    always @(posedge clk)
    begin
        face_result_t got;
        if (rst_n && strobe === 1'b1) begin
            got.face_valid = face_valid;
            got.face_dir   = face_dir;
            got.index[0]   = index_a;
            got.index[1]   = index_b;
            got.index[2]   = index_c;
            got.index[3]   = index_d;
            got.index[4]   = index_e;
            got.index[5]   = index_f;
            got.last       = last;
            board.check_face(got);
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog expired after %0d idle cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Drives one command after a random gap and waits for its transfer.
    task automatic send_command(input logic op, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                                input logic s);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        opcode <= op;
        pos_x  <= x;
        pos_y  <= y;
        pos_z  <= z;
        solid  <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(op, x, y, z, s);
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (board.pending() > 0)
            @(posedge clk);
    endtask

    // Random command, mostly clustered in a small window so neighbors are often solid.
    task automatic send_random(input int base_x, input int base_y, input int base_z);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               op;
        logic               s;
        op = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_QUERY;
        if ($urandom_range(0, 99) < 8) begin
            x = COORD_W'($urandom_range(0, 15));
            y = COORD_W'($urandom_range(0, 15));
            z = COORD_W'($urandom_range(0, 15));
            s = 1'($urandom_range(0, 1));
        end else begin
            x = COORD_W'(base_x + int'($urandom_range(0, 3)));
            y = COORD_W'(base_y + int'($urandom_range(0, 3)));
            z = COORD_W'(base_z + int'($urandom_range(0, 3)));
            if ($urandom_range(0, 9) == 0)
                x = $urandom_range(0, 1) ? 4'd15 : 4'd0;
            if ($urandom_range(0, 9) == 0)
                z = $urandom_range(0, 1) ? 4'd15 : 4'd0;
            s = (op == OP_WRITE) ? ($urandom_range(0, 99) < 75) : 1'($urandom_range(0, 1));
        end
        send_command(op, x, y, z, s);
    endtask

    // Main sequence: reset, directed cases, random traffic, then drain and report.
    initial
    begin
        int base_x;
        int base_y;
        int base_z;
        board   = new();
        no_gaps = 1'b0;
        rst_n   = 1'b0;
        start   = 1'b0;
        opcode  = OP_WRITE;
        pos_x   = '0;
        pos_y   = '0;
        pos_z   = '0;
        solid   = 1'b0;
        base_x  = 0;
        base_y  = 0;
        base_z  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Queries of empty voxels, with the ignored solid bit both ways.
        send_command(OP_QUERY, 4'd0, 4'd0, 4'd0, 1'b1);
        send_command(OP_QUERY, 4'd15, 4'd15, 4'd15, 1'b0);
        // Isolated voxels at both corners of the cube expose all six faces.
        send_command(OP_WRITE, 4'd0, 4'd0, 4'd0, 1'b1);
        send_command(OP_QUERY, 4'd0, 4'd0, 4'd0, 1'b0);
        send_command(OP_WRITE, 4'd15, 4'd15, 4'd15, 1'b1);
        send_command(OP_QUERY, 4'd15, 4'd15, 4'd15, 1'b1);
        // A fully enclosed voxel gives the single result marked not valid.
        send_command(OP_WRITE, 4'd5, 4'd5, 4'd5, 1'b1);
        send_command(OP_WRITE, 4'd4, 4'd5, 4'd5, 1'b1);
        send_command(OP_WRITE, 4'd6, 4'd5, 4'd5, 1'b1);
        send_command(OP_WRITE, 4'd5, 4'd4, 4'd5, 1'b1);
        send_command(OP_WRITE, 4'd5, 4'd6, 4'd5, 1'b1);
        send_command(OP_WRITE, 4'd5, 4'd5, 4'd4, 1'b1);
        send_command(OP_WRITE, 4'd5, 4'd5, 4'd6, 1'b1);
        send_command(OP_QUERY, 4'd5, 4'd5, 4'd5, 1'b0);
        send_command(OP_QUERY, 4'd4, 4'd5, 4'd5, 1'b0);
        // Clearing a voxel reopens its neighbor's face.
        send_command(OP_WRITE, 4'd5, 4'd5, 4'd5, 1'b0);
        send_command(OP_QUERY, 4'd5, 4'd5, 4'd5, 1'b0);
        send_command(OP_QUERY, 4'd4, 4'd5, 4'd5, 1'b0);
        send_command(OP_WRITE, 4'd0, 4'd0, 4'd0, 1'b0);
        send_command(OP_QUERY, 4'd0, 4'd0, 4'd0, 1'b0);
        send_command(OP_WRITE, 4'd15, 4'd0, 4'd15, 1'b1);
        send_command(OP_QUERY, 4'd15, 4'd0, 4'd15, 1'b0);
        send_command(OP_WRITE, 4'd14, 4'd0, 4'd15, 1'b1);
        send_command(OP_QUERY, 4'd15, 4'd0, 4'd15, 1'b0);
        drain_results();

        // Random traffic in bursts, each around its own window, some bursts without gaps.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 30 == 0) begin
                no_gaps = ($urandom_range(0, 3) == 0);
                base_x  = $urandom_range(0, 12);
                base_y  = $urandom_range(0, 12);
                base_z  = $urandom_range(0, 12);
            end
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            send_random(base_x, base_y, base_z);
        end
        start <= 1'b0;

        // Wait for the last results, then give the back part time to go quiet.
        while (board.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, board.pending());
            board.errors++;
        end

        $display("Covered %0d writes and %0d queries: %0d faces and %0d no-face results.",
                 board.writes, board.queries, board.faces, board.bare_results);
        $display("Mismatches and unexpected results: %0d", board.errors);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
